>>> sv/fcfs_rr_quantum_job_queue_macros.svh
// Assertion macros for the job queue scheduler.
`ifndef FCFS_RR_QUANTUM_JOB_QUEUE_MACROS_SVH
`define FCFS_RR_QUANTUM_JOB_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCFSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCFSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fcfsq_pkg.sv
// Shared types and constants for the job queue scheduler.
package fcfsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int LIFE_W      = 10;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 5;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [LIFE_W-1:0] QUANTUM_RESET = LIFE_W'(100);

    localparam logic MODE_PRODUCE = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    localparam logic ALG_FCFS = 1'b0;
    localparam logic ALG_RR   = 1'b1;

    localparam logic REG_ALGORITHM = 1'b0;
    localparam logic REG_QUANTUM   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DONE     = 3'd3,
        ST_PARTIAL  = 3'd4
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   job_id;
        logic [LIFE_W-1:0] job_life;
    } t_item;

    typedef struct packed {
        logic              algorithm;
        logic [LIFE_W-1:0] quantum;
    } t_cfg;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [ID_W-1:0]   wr_id;
        logic [LIFE_W-1:0] wr_life;
    } t_ring_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              full;
        logic              empty;
        logic [ID_W-1:0]   head_id;
        logic [LIFE_W-1:0] head_life;
    } t_ring_stat;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   served_id;
        logic [LIFE_W-1:0] work_units;
        logic [LIFE_W-1:0] life_left;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

endpackage

>>> sv/fcfs_rr_quantum_job_queue.sv
// Top level of the FCFS / round-robin quantum job queue scheduler.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_mode, i_job_id, i_job_life
//   out       output     o_out_valid / i_out_ready o_status, o_served_id,
//                                                  o_work_units, o_life_left,
//                                                  o_occupancy
//   cfg       input      APB, pready tied high     algorithm @0x0, quantum @0x4
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// from the input register through the decision into the result register.
// The ring is read at the head pointer and written at the tail in the same cycle.
// Synchronous active-low reset empties the queue and restores FCFS, quantum 100.
// A stalled output holds the result; the input register then fills and stalls in.
`include "fcfs_rr_quantum_job_queue_macros.svh"

module fcfs_rr_quantum_job_queue
    import fcfsq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [ID_W-1:0]     i_job_id,
    input  logic [LIFE_W-1:0]   i_job_life,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_served_id,
    output logic [LIFE_W-1:0]   o_work_units,
    output logic [LIFE_W-1:0]   o_life_left,
    output logic [OCC_W-1:0]    o_occupancy,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_exec;
    t_cfg       w_cfg;
    t_ring_cmd  w_sched_cmd;
    t_ring_cmd  w_ring_cmd;
    t_ring_stat w_stat;
    t_result    w_res;
    logic       w_rotate;
    logic       w_out_stall;

    assign w_exec     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.mode     <= i_mode;
            r_in.job_id   <= i_job_id;
            r_in.job_life <= i_job_life;
        end
        if (w_exec) begin
            r_out <= w_res;
        end
    end

    fcfsq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fcfsq_sched u_sched (
        .i_item (r_in),
        .i_cfg  (w_cfg),
        .i_stat (w_stat),
        .o_cmd  (w_sched_cmd),
        .o_res  (w_res)
    );

    always_comb begin
        w_ring_cmd      = w_sched_cmd;
        w_ring_cmd.push = w_sched_cmd.push & w_exec;
        w_ring_cmd.pop  = w_sched_cmd.pop & w_exec;
    end

    fcfsq_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ring_cmd),
        .o_stat  (w_stat)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_served_id  = r_out.served_id;
    assign o_work_units = r_out.work_units;
    assign o_life_left  = r_out.life_left;
    assign o_occupancy  = r_out.occupancy;

    assign w_rotate    = w_exec && (w_res.status == ST_PARTIAL);
    assign w_out_stall = r_out_valid && !i_out_ready;

    `FCFSQ_ASSERT_NOW(a_count_in_range, 1'b1, w_stat.count <= CNT_W'(QUEUE_DEPTH), "overfull")
    `FCFSQ_ASSERT_NEXT(a_exec_loads_out, w_exec, o_out_valid, "result not presented")
    `FCFSQ_ASSERT_NEXT(a_rotate_count, w_rotate, $stable(w_stat.count), "count moved")
    `FCFSQ_ASSERT_NEXT(a_out_held, w_out_stall, o_out_valid && $stable(r_out), "result changed")

endmodule

>>> sv/fcfsq_cfg.sv
// APB register block: scheduling discipline and round-robin quantum.
module fcfsq_cfg
    import fcfsq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic              r_algorithm;
    logic [LIFE_W-1:0] r_quantum;
    logic              w_wr;
    logic              w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_sel  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm <= ALG_FCFS;
            r_quantum   <= QUANTUM_RESET;
        end else if (w_wr) begin
            if (w_sel == REG_ALGORITHM) begin
                r_algorithm <= pwdata[0];
            end else begin
                r_quantum <= pwdata[LIFE_W-1:0];
            end
        end
    end

    always_comb begin
        if (w_sel == REG_ALGORITHM) begin
            prdata = {{(DATA_W-1){1'b0}}, r_algorithm};
        end else begin
            prdata = {{(DATA_W-LIFE_W){1'b0}}, r_quantum};
        end
    end

    assign o_cfg.algorithm = r_algorithm;
    assign o_cfg.quantum   = r_quantum;

endmodule

>>> sv/fcfsq_ring.sv
// Ring buffer of jobs with head and tail pointers and a fill count.
module fcfsq_ring
    import fcfsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ring_cmd  i_cmd,
    output t_ring_stat o_stat
);

    logic [ID_W-1:0]   r_ids   [QUEUE_DEPTH];
    logic [LIFE_W-1:0] r_lives [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  n_tail;
    logic [CNT_W-1:0]  n_count;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    always_comb begin
        n_head  = i_cmd.pop  ? next_slot(r_head) : r_head;
        n_tail  = i_cmd.push ? next_slot(r_tail) : r_tail;
        n_count = r_count;
        if (i_cmd.push && !i_cmd.pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ids[r_tail]   <= i_cmd.wr_id;
            r_lives[r_tail] <= i_cmd.wr_life;
        end
    end

    assign o_stat.count     = r_count;
    assign o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.head_id   = r_ids[r_head];
    assign o_stat.head_life = r_lives[r_head];

endmodule

>>> sv/fcfsq_sched.sv
// Scheduling decision for one transaction: ring command and result.
module fcfsq_sched
    import fcfsq_pkg::*;
(
    input  t_item      i_item,
    input  t_cfg       i_cfg,
    input  t_ring_stat i_stat,
    output t_ring_cmd  o_cmd,
    output t_result    o_res
);

    logic [CNT_W-1:0] w_occ;

    always_comb begin
        o_cmd.push    = 1'b0;
        o_cmd.pop     = 1'b0;
        o_cmd.wr_id   = i_item.job_id;
        o_cmd.wr_life = i_item.job_life;

        o_res.status     = ST_EMPTY;
        o_res.served_id  = '0;
        o_res.work_units = '0;
        o_res.life_left  = '0;

        if (i_item.mode == MODE_PRODUCE) begin
            if (i_stat.full) begin
                o_res.status = ST_FULL;
            end else begin
                o_cmd.push      = 1'b1;
                o_res.status    = ST_APPENDED;
                o_res.served_id = i_item.job_id;
            end
        end else if (!i_stat.empty) begin
            o_res.served_id = i_stat.head_id;
            o_cmd.pop       = 1'b1;
            if (i_cfg.algorithm == ALG_FCFS) begin
                o_res.status     = ST_DONE;
                o_res.work_units = i_stat.head_life;
            end else if (i_stat.head_life >= i_cfg.quantum) begin
                // rotate to tail with the quantum taken off
                o_cmd.push       = 1'b1;
                o_cmd.wr_id      = i_stat.head_id;
                o_cmd.wr_life    = i_stat.head_life - i_cfg.quantum;
                o_res.status     = ST_PARTIAL;
                o_res.work_units = i_cfg.quantum;
                o_res.life_left  = i_stat.head_life - i_cfg.quantum;
            end else begin
                o_res.status     = ST_DONE;
                o_res.work_units = LIFE_W'(1);
            end
        end

        w_occ = i_stat.count;
        if (o_cmd.push && !o_cmd.pop) begin
            w_occ = i_stat.count + CNT_W'(1);
        end else if (o_cmd.pop && !o_cmd.push) begin
            w_occ = i_stat.count - CNT_W'(1);
        end
        o_res.occupancy = OCC_W'(w_occ);
    end

endmodule
